// File: rtl/flat_json_object_parser_macros.svh
// Assertion macros used by the checker file.
`ifndef FLAT_JSON_OBJECT_PARSER_MACROS_SVH
`define FLAT_JSON_OBJECT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FJOP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define FJOP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication that is checked through reset as well.
`define FJOP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/fjop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fjop_pkg;

  localparam int unsigned MAX_STRING_DEF = 63;

  typedef enum logic [2:0] {
    KIND_KEY_CHAR = 3'd0,
    KIND_VAL_CHAR = 3'd1,
    KIND_KEY_END  = 3'd2,
    KIND_PAIR_END = 3'd3,
    KIND_ACCEPT   = 3'd4,
    KIND_REJECT   = 3'd5
  } kind_t;

endpackage

`default_nettype wire

// File: rtl/fjop_intf.sv
`timescale 1ns / 1ps
`default_nettype none

// Text byte channel.
interface fjop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// Parse event channel.
interface fjop_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/flat_json_object_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for a flat JSON object whose keys and values are strings.
// in_ch carries one document byte per beat; a zero byte ends the document.
// out_ch carries parse events: kind 0/1 key/value character (decoded, in
// data_byte), 2 key end, 3 pair end, 4 accepted, 5 rejected (data_byte is
// zero for kinds 2..5). A byte yields zero or one event.
// Throughput: one byte per cycle while the skid register is empty. The byte
// is decoded against the phase register in the accept cycle, and its event is
// written to the output register, or to the skid register while an event waits.
// Stall: a two-entry output buffer (output register plus skid register)
// lets in_ch keep taking a byte while an event waits for out_ch.ready.
// in_ch.ready drops only when the skid register is occupied, and rises
// again as soon as the receiver takes a beat.
// Reset (rst_n low, synchronous): phase returns to "expect opening brace",
// the length counter clears and both buffer entries are emptied.
// After a reject on a nonzero byte, bytes are dropped silently until the next zero byte.
module flat_json_object_parser #(
  parameter int unsigned MAX_STRING = fjop_pkg::MAX_STRING_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fjop_in_if.sink    in_ch,
  fjop_out_if.source out_ch
);

  localparam int unsigned LenW = $clog2(MAX_STRING + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_STRING);

  localparam logic [7:0] ChOpen   = 8'h7B; // {
  localparam logic [7:0] ChClose  = 8'h7D; // }
  localparam logic [7:0] ChColon  = 8'h3A; // :
  localparam logic [7:0] ChComma  = 8'h2C; // ,
  localparam logic [7:0] ChQuote  = 8'h22; // "
  localparam logic [7:0] ChBslash = 8'h5C; // backslash
  localparam logic [7:0] ChSlash  = 8'h2F; // /
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChBs     = 8'h08;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [3:0] {
    PH_OPEN      = 4'd0,
    PH_FIRST     = 4'd1,
    PH_KEY_START = 4'd2,
    PH_KEY_STR   = 4'd3,
    PH_KEY_ESC   = 4'd4,
    PH_COLON     = 4'd5,
    PH_VAL_START = 4'd6,
    PH_VAL_STR   = 4'd7,
    PH_VAL_ESC   = 4'd8,
    PH_AFTER_VAL = 4'd9,
    PH_TRAIL     = 4'd10,
    PH_DRAIN     = 4'd11
  } phase_t;

  // Parser state.
  phase_t          phase_r, phase_nxt;
  logic [LenW-1:0] len_r, len_nxt;

  // Output register and skid register.
  logic            out_valid_r, skid_valid_r;
  fjop_pkg::kind_t out_kind_r, skid_kind_r;
  logic [7:0]      out_data_r, skid_data_r;

  // Event produced by the current byte.
  logic            res_valid;
  fjop_pkg::kind_t res_kind;
  logic [7:0]      res_data;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       c_space, c_nul;
  logic       esc_ok;
  logic [7:0] esc_ch;
  logic       in_key;
  logic [7:0] char_in;
  logic       char_ok;

  assign c       = in_ch.text_byte;
  assign c_space = (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChCr);
  assign c_nul   = (c == ChNul);

  // Escape decode for the byte after a backslash.
  always_comb begin
    esc_ok = 1'b1;
    esc_ch = c;
    unique case (c)
      ChQuote, ChBslash, ChSlash: esc_ch = c;
      8'h6E: esc_ch = ChLf;   // n
      8'h74: esc_ch = ChTab;  // t
      8'h72: esc_ch = ChCr;   // r
      8'h62: esc_ch = ChBs;   // b
      8'h66: esc_ch = ChFf;   // f
      default: esc_ok = 1'b0;
    endcase
  end

  assign in_key  = (phase_r == PH_KEY_STR) || (phase_r == PH_KEY_ESC);
  assign char_in = ((phase_r == PH_KEY_ESC) || (phase_r == PH_VAL_ESC)) ? esc_ch : c;
  assign char_ok = (len_r < LenMax);

  // Next phase and event for one byte.
  always_comb begin
    phase_nxt = phase_r;
    len_nxt   = len_r;
    res_valid = 1'b0;
    res_kind  = fjop_pkg::KIND_REJECT;
    res_data  = 8'h00;
    unique case (phase_r)
      PH_OPEN: begin
        if (c == ChOpen) begin
          phase_nxt = PH_FIRST;
        end else if (!c_space) begin
          res_valid = 1'b1;
        end
      end
      PH_FIRST: begin
        if (c == ChClose) begin
          phase_nxt = PH_TRAIL;
        end else if (c == ChQuote) begin
          phase_nxt = PH_KEY_STR;
          len_nxt   = '0;
        end else if (!c_space) begin
          res_valid = 1'b1;
        end
      end
      PH_KEY_START, PH_VAL_START: begin
        if (c == ChQuote) begin
          phase_nxt = (phase_r == PH_KEY_START) ? PH_KEY_STR : PH_VAL_STR;
          len_nxt   = '0;
        end else if (!c_space) begin
          res_valid = 1'b1;
        end
      end
      PH_KEY_STR, PH_VAL_STR: begin
        if (c_nul) begin
          res_valid = 1'b1;
        end else if (c == ChQuote) begin
          len_nxt   = '0;
          res_valid = 1'b1;
          phase_nxt = in_key ? PH_COLON : PH_AFTER_VAL;
          res_kind  = in_key ? fjop_pkg::KIND_KEY_END : fjop_pkg::KIND_PAIR_END;
        end else if (c == ChBslash) begin
          phase_nxt = in_key ? PH_KEY_ESC : PH_VAL_ESC;
        end else begin
          res_valid = 1'b1;
          if (char_ok) begin
            len_nxt  = len_r + LenW'(1);
            res_kind = in_key ? fjop_pkg::KIND_KEY_CHAR : fjop_pkg::KIND_VAL_CHAR;
            res_data = char_in;
          end
        end
      end
      PH_KEY_ESC, PH_VAL_ESC: begin
        res_valid = 1'b1;
        if (esc_ok && char_ok) begin
          len_nxt   = len_r + LenW'(1);
          phase_nxt = in_key ? PH_KEY_STR : PH_VAL_STR;
          res_kind  = in_key ? fjop_pkg::KIND_KEY_CHAR : fjop_pkg::KIND_VAL_CHAR;
          res_data  = char_in;
        end
      end
      PH_COLON: begin
        if (c == ChColon) begin
          phase_nxt = PH_VAL_START;
        end else if (!c_space) begin
          res_valid = 1'b1;
        end
      end
      PH_AFTER_VAL: begin
        if (c == ChComma) begin
          phase_nxt = PH_KEY_START;
        end else if (c == ChClose) begin
          phase_nxt = PH_TRAIL;
        end else if (!c_space) begin
          res_valid = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (c_nul) begin
          phase_nxt = PH_OPEN;
          len_nxt   = '0;
          res_valid = 1'b1;
          res_kind  = fjop_pkg::KIND_ACCEPT;
        end else if (!c_space) begin
          res_valid = 1'b1;
        end
      end
      default: begin
        // Drain, and any unused code: drop bytes until the terminator.
        if (c_nul) begin
          phase_nxt = PH_OPEN;
          len_nxt   = '0;
        end
      end
    endcase
    // Every reject restarts on the terminator, else drains up to it.
    if (res_valid && (res_kind == fjop_pkg::KIND_REJECT)) begin
      phase_nxt = c_nul ? PH_OPEN : PH_DRAIN;
      len_nxt   = '0;
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && !skid_valid_r;
  assign out_fire    = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_OPEN;
      len_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r <= phase_nxt;
        len_r   <= len_nxt;
      end
      if (out_fire) begin
        if (skid_valid_r) begin
          // Advance the skid entry; no byte is taken while it is full, so it empties.
          out_kind_r   <= skid_kind_r;
          out_data_r   <= skid_data_r;
          skid_valid_r <= in_fire && res_valid;
          skid_kind_r  <= res_kind;
          skid_data_r  <= res_data;
        end else begin
          out_valid_r <= in_fire && res_valid;
          out_kind_r  <= res_kind;
          out_data_r  <= res_data;
        end
      end else if (!out_valid_r) begin
        out_valid_r <= in_fire && res_valid;
        out_kind_r  <= res_kind;
        out_data_r  <= res_data;
      end else if (in_fire && res_valid) begin
        // Hold the waiting beat; park the new event in the skid register.
        skid_valid_r <= 1'b1;
        skid_kind_r  <= res_kind;
        skid_data_r  <= res_data;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_kind_r;
  assign out_ch.data_byte = out_data_r;

endmodule

`default_nettype wire

// File: rtl/fjop_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "flat_json_object_parser_macros.svh"

module fjop_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_data_byte
);

  logic out_is_char;
  logic out_code_ok;

  assign out_is_char = (out_kind == fjop_pkg::KIND_KEY_CHAR) ||
                       (out_kind == fjop_pkg::KIND_VAL_CHAR);
  assign out_code_ok = out_is_char ||
                       (out_kind == fjop_pkg::KIND_KEY_END) ||
                       (out_kind == fjop_pkg::KIND_PAIR_END) ||
                       (out_kind == fjop_pkg::KIND_ACCEPT) ||
                       (out_kind == fjop_pkg::KIND_REJECT);

  `FJOP_ASSERT_IMP(a_mark_no_data, clk, rst_n, out_valid && !out_is_char, out_data_byte == 8'h00, "event without character carries data")
  `FJOP_ASSERT_IMP(a_kind_code, clk, rst_n, out_valid, out_code_ok, "undefined event kind")
  `FJOP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_data_byte), "stalled event changed")
  `FJOP_ASSERT_ALWAYS(a_reset_empty, clk, $past(!rst_n), !out_valid && in_ready, "buffer not empty after reset")
  `FJOP_ASSERT_NXT(a_ready_after_take, clk, rst_n, out_valid && out_ready, in_ready, "input held off after an event was taken")

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind flat_json_object_parser fjop_checker u_fjop_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_data_byte (out_ch.data_byte)
);

`default_nettype wire

// File: tb/tb_flat_json_object_parser.sv
`timescale 1ns / 1ps

module tb_flat_json_object_parser;
  import fjop_pkg::*;

  localparam int unsigned MAX_STR = MAX_STRING_DEF;

  // Bytes with a meaning to the parser
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [7:0] WS_CHARS [4] = '{CH_SP, CH_TAB, CH_LF, CH_CR};
  // Letters that may follow a backslash
  localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH,
                                             "n", "t", "r", "b", "f"};

  typedef enum logic [3:0] {
    P_OPEN, P_FIRST, P_KEY_START, P_KEY_STR, P_KEY_ESC, P_COLON,
    P_VAL_START, P_VAL_STR, P_VAL_ESC, P_AFTER_VAL, P_TRAIL, P_DRAIN
  } doc_phase_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
  } parse_event_t;

  logic clk;
  logic rst_n;

  fjop_in_if  in_if ();
  fjop_out_if out_if ();

  flat_json_object_parser #(.MAX_STRING(MAX_STR)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // Predicted parser state
  doc_phase_t   doc_phase = P_OPEN;
  logic [7:0]   str_len   = '0;
  parse_event_t event_q[$];

  logic [7:0]   doc_buf[$];
  parse_event_t got_ev;
  int           err_count  = 0;
  int           bytes_sent = 0;
  int           stall_cnt  = 0;
  bit           idle_on    = 1'b1;
  bit           bad_esc_on = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Event predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_ws(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic void note_event(input kind_t k, input logic [7:0] d);
    parse_event_t ev;
    ev.kind = k;
    ev.data = d;
    event_q.push_back(ev);
  endfunction

  // A zero byte restarts at once; any other bad byte drains to the zero byte.
  function automatic void reject_byte(input logic [7:0] c);
    doc_phase = (c == CH_NUL) ? P_OPEN : P_DRAIN;
    str_len   = '0;
    note_event(KIND_REJECT, 8'h00);
  endfunction

  function automatic void append_char(input logic [7:0] ch, input bit key,
                                      input logic [7:0] c);
    if (str_len >= MAX_STR) begin
      reject_byte(c);
    end else begin
      str_len++;
      doc_phase = key ? P_KEY_STR : P_VAL_STR;
      note_event(key ? KIND_KEY_CHAR : KIND_VAL_CHAR, ch);
    end
  endfunction

  function automatic bit decode_escape(input logic [7:0] c, output logic [7:0] ch);
    ch = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: return 1'b1;
      "n": ch = CH_LF;
      "t": ch = CH_TAB;
      "r": ch = CH_CR;
      "b": ch = CH_BS;
      "f": ch = CH_FF;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void parse_byte(input logic [7:0] c);
    logic [7:0] ch;
    bit         key;
    case (doc_phase)
      P_OPEN: begin
        if (!is_ws(c)) begin
          if (c == CH_LBRACE) doc_phase = P_FIRST;
          else reject_byte(c);
        end
      end
      P_FIRST: begin
        if (!is_ws(c)) begin
          if (c == CH_RBRACE) doc_phase = P_TRAIL;
          else if (c == CH_QUOTE) begin
            doc_phase = P_KEY_STR;
            str_len   = '0;
          end else reject_byte(c);
        end
      end
      P_KEY_START: begin
        if (!is_ws(c)) begin
          if (c == CH_QUOTE) begin
            doc_phase = P_KEY_STR;
            str_len   = '0;
          end else reject_byte(c);
        end
      end
      P_KEY_STR, P_VAL_STR: begin
        key = (doc_phase == P_KEY_STR);
        if (c == CH_NUL) begin
          reject_byte(c);
        end else if (c == CH_QUOTE) begin
          str_len = '0;
          if (key) begin
            doc_phase = P_COLON;
            note_event(KIND_KEY_END, 8'h00);
          end else begin
            doc_phase = P_AFTER_VAL;
            note_event(KIND_PAIR_END, 8'h00);
          end
        end else if (c == CH_BSLASH) begin
          doc_phase = key ? P_KEY_ESC : P_VAL_ESC;
        end else begin
          append_char(c, key, c);
        end
      end
      P_KEY_ESC, P_VAL_ESC: begin
        key = (doc_phase == P_KEY_ESC);
        if (!decode_escape(c, ch)) reject_byte(c);
        else append_char(ch, key, c);
      end
      P_COLON: begin
        if (!is_ws(c)) begin
          if (c == CH_COLON) doc_phase = P_VAL_START;
          else reject_byte(c);
        end
      end
      P_VAL_START: begin
        if (!is_ws(c)) begin
          if (c == CH_QUOTE) begin
            doc_phase = P_VAL_STR;
            str_len   = '0;
          end else reject_byte(c);
        end
      end
      P_AFTER_VAL: begin
        if (!is_ws(c)) begin
          if (c == CH_COMMA) doc_phase = P_KEY_START;
          else if (c == CH_RBRACE) doc_phase = P_TRAIL;
          else reject_byte(c);
        end
      end
      P_TRAIL: begin
        if (!is_ws(c)) begin
          if (c == CH_NUL) begin
            doc_phase = P_OPEN;
            str_len   = '0;
            note_event(KIND_ACCEPT, 8'h00);
          end else reject_byte(c);
        end
      end
      default: begin
        // Drain: drop everything up to the zero byte, silently
        if (c == CH_NUL) begin
          doc_phase = P_OPEN;
          str_len   = '0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver, receiver stalls and event checker
  // ---------------------------------------------------------------------------

  // Send one byte; predict its event once the beat is taken.
  task automatic push_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.text_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    parse_byte(b);
    bytes_sent++;
  endtask

  initial out_if.ready = 1'b0;

  // Hold ready low in bursts of random length while idling is on.
  always @(posedge clk) begin
    if (stall_cnt != 0) begin
      stall_cnt    <= stall_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt    <= $urandom_range(0, 6);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare every event beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (event_q.size() == 0) begin
        $display("%0t: unexpected event, expected none actual kind %0d data %02h",
                 $time, out_if.kind, out_if.data_byte);
        err_count++;
      end else begin
        got_ev = event_q.pop_front();
        if (out_if.kind !== got_ev.kind) begin
          $display("%0t: kind mismatch, expected %0d (%s) actual %0d", $time,
                   got_ev.kind, got_ev.kind.name(), out_if.kind);
          err_count++;
        end
        if (out_if.data_byte !== got_ev.data) begin
          $display("%0t: data_byte mismatch, expected %02h actual %02h", $time,
                   got_ev.data, out_if.data_byte);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Document builders
  // ---------------------------------------------------------------------------

  function automatic void put(input logic [7:0] b);
    doc_buf.push_back(b);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void pad_space();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    repeat (n) put(WS_CHARS[$urandom_range(0, 3)]);
  endfunction

  // Mostly short strings, now and then near or at the length limit, or one past it.
  function automatic int pick_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_STR - 3, MAX_STR + 1)
                                        : $urandom_range(0, 8);
  endfunction

  // String body of n decoded characters: escapes, raw bytes and printables.
  function automatic void fill_string(input int n);
    logic [7:0] b;
    int         sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 9);
      if (bad_esc_on && $urandom_range(0, 15) == 0) begin
        put(CH_BSLASH);
        put(8'($urandom_range(0, 255)));
      end else if (sel < 2) begin
        put(CH_BSLASH);
        put(ESC_LETTERS[$urandom_range(0, 7)]);
      end else begin
        do b = 8'((sel < 4) ? $urandom_range(1, 255) : $urandom_range(32, 126));
        while (b == CH_QUOTE || b == CH_BSLASH);
        put(b);
      end
    end
  endfunction

  function automatic void build_object();
    int pairs;
    pad_space();
    put(CH_LBRACE);
    pad_space();
    pairs = $urandom_range(0, 4);
    for (int i = 0; i < pairs; i++) begin
      if (i != 0) begin
        put(CH_COMMA);
        pad_space();
      end
      put(CH_QUOTE);
      fill_string(pick_len());
      put(CH_QUOTE);
      pad_space();
      put(CH_COLON);
      pad_space();
      put(CH_QUOTE);
      fill_string(pick_len());
      put(CH_QUOTE);
      pad_space();
    end
    put(CH_RBRACE);
    pad_space();
    put(CH_NUL);
  endfunction

  task automatic send_doc();
    foreach (doc_buf[i]) push_byte(doc_buf[i]);
    doc_buf.delete();
  endtask

  task automatic send_text(input string s);
    put_text(s);
    put(CH_NUL);
    send_doc();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty object, empty document, whitespace-only document, padded empty object.
  task automatic test_minimal_docs();
    send_text("{}");
    send_text("");
    send_text(" \t\r\n");
    send_text(" {\t}\n ");
  endtask

  // Every allowed escape in a value and one in the key, then bad escapes on both sides.
  task automatic test_escapes();
    put_text("{\"\\/\":\"");
    foreach (ESC_LETTERS[i]) begin
      put(CH_BSLASH);
      put(ESC_LETTERS[i]);
    end
    put_text("\"}");
    put(CH_NUL);
    send_doc();
    send_text("{\"a\\u0041\"}");
    send_text("{\"a\":\"\\x\"}");
  endtask

  // Misplaced bytes, early ends and trailing content.
  task automatic test_syntax_errors();
    send_text("x{}");
    send_text("{\"a\" \"b\"}");
    send_text("{\"a\":\"b\",}");
    send_text("{\"k\":\"v\"");
    send_text("{\"k");
    send_text("{\"k\\");
    send_text("{} x");
  endtask

  // Control and high bytes pass through strings as literal characters.
  task automatic test_raw_bytes();
    put_text("{\"");
    put(8'h01);
    put(CH_TAB);
    put(8'h7F);
    put(8'h80);
    put(8'hFF);
    put_text("\":\"\"}");
    put(CH_NUL);
    send_doc();
  endtask

  // Strings of exactly the limit pass; one character more is rejected.
  task automatic test_length_limit();
    put_text("{\"");
    repeat (MAX_STR) put("k");
    put_text("\":\"");
    repeat (MAX_STR - 1) put("v");
    put(CH_BSLASH);
    put("n");
    put_text("\"}");
    put(CH_NUL);
    send_doc();
    put_text("{\"a\":\"");
    repeat (MAX_STR + 1) put("v");
    put_text("\"}");
    put(CH_NUL);
    send_doc();
  endtask

  // Mostly well-formed objects; the rest truncated, mutated, with bad
  // escapes, or plain noise.
  task automatic test_random_docs(input int upto);
    int mode;
    int p;
    while (bytes_sent < upto) begin
      mode       = $urandom_range(0, 9);
      bad_esc_on = (mode == 7);
      if (mode == 9) begin
        repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
        put(CH_NUL);
      end else begin
        build_object();
      end
      p = $urandom_range(0, doc_buf.size() - 2);
      if (mode == 6) begin
        while (doc_buf.size() > p) void'(doc_buf.pop_back());
        put(CH_NUL);
      end else if (mode == 8) begin
        if ($urandom_range(0, 1) == 1) doc_buf[p] = 8'($urandom_range(0, 255));
        else doc_buf.insert(p, 8'($urandom_range(0, 255)));
      end
      send_doc();
    end
    bad_esc_on = 1'b0;
  endtask

  // Run out the stream with both sides at full rate.
  task automatic test_full_rate(input int upto);
    idle_on = 1'b0;
    test_random_docs(upto);
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.text_byte = 8'h00;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_minimal_docs();
    test_escapes();
    test_syntax_errors();
    test_raw_bytes();
    test_length_limit();
    test_random_docs(950);
    test_full_rate(1150);

    in_if.valid <= 1'b0;
    while (event_q.size() != 0) @(posedge clk);
    // The output and skid registers may still hold events; allow a margin for strays
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
